### rtl/core/ctig_pkg.sv
// ----------------------------------------------------------------------------
// ctig_pkg
// Types and constant tables for the cube to tetrahedra index generator.
// ----------------------------------------------------------------------------
package ctig_pkg;

  localparam int unsigned NumTets = 6;

  localparam logic [1:0] REG_CUBES_X = 2'd0;
  localparam logic [1:0] REG_CUBES_Y = 2'd1;
  localparam logic [1:0] REG_CUBES_Z = 2'd2;

  typedef logic [2:0] corner_t;
  typedef logic [2:0] offset_t;  // {dx, dy, dz}

  localparam corner_t TET_CORNER [NumTets][4] = '{
    '{3'd3, 3'd5, 3'd1, 3'd2},
    '{3'd3, 3'd5, 3'd4, 3'd0},
    '{3'd3, 3'd5, 3'd2, 3'd4},
    '{3'd4, 3'd3, 3'd0, 3'd6},
    '{3'd3, 3'd5, 3'd0, 3'd1},
    '{3'd1, 3'd5, 3'd7, 3'd2}
  };

  localparam offset_t CORNER_OFS [8] = '{
    3'b000, 3'b100, 3'b111, 3'b101, 3'b011, 3'b010, 3'b001, 3'b110
  };

  typedef struct packed {
    logic        v;
    logic [2:0]  cnt;
    logic [7:0]  rem;
    logic [23:0] quo;
    logic [23:0] idx;
    logic [15:0] cxy;
    logic [23:0] tot;
    logic        err;
  } div1_t;

  typedef struct packed {
    logic        v;
    logic [2:0]  cnt;
    logic [7:0]  rem;
    logic [23:0] quo;
    logic [7:0]  z;
    logic        err;
  } div2_t;

  typedef struct packed {
    logic        v;
    logic [2:0]  cnt;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [8:0]  nz;
    logic [16:0] m;
    logic [16:0] snz;
    logic [23:0] base;
    logic        err;
  } lin_t;

  typedef struct packed {
    logic        v;
    logic [2:0]  t;
    logic [8:0]  nz;
    logic [16:0] snz;
    logic [23:0] base;
    logic        err;
  } emit_t;

  // four restoring division steps, remainder stays below the divisor when that is nonzero
  function automatic logic [31:0] div4(input logic [7:0] r_in, input logic [23:0] q_in,
                                       input logic [7:0] d);
    logic [7:0]  r;
    logic [23:0] q;
    logic [8:0]  t;
    r = r_in;
    q = q_in;
    for (int i = 0; i < 4; i++) begin
      t = {r, q[23]};
      q = {q[22:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        q[0] = 1'b1;
      end
      r = t[7:0];
    end
    return {r, q};
  endfunction

endpackage

### rtl/core/cube_tetrahedra_index_generator.sv
// ----------------------------------------------------------------------------
// cube_tetrahedra_index_generator
// A new request is taken whenever busy is low, also while earlier cubes are in
// flight; the pace is set by the 4-bit-per-cycle divider stages and by the six
// results sharing one result port.
// Reset: asynchronous, active low; clears all stages, counts return to 1.
// The receiver cannot stall, results are never held back.
// ----------------------------------------------------------------------------
module cube_tetrahedra_index_generator import ctig_pkg::*; #(
  parameter int MAX_CUBES_PER_AXIS = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] cube_index_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  tet_number_o,
  output logic [23:0] vertex_a_o,
  output logic [23:0] vertex_b_o,
  output logic [23:0] vertex_c_o,
  output logic [23:0] vertex_d_o,
  output logic        index_error_o,
  output logic        last_of_cube_o
);

  logic [7:0] cx_q, cy_q, cz_q, clamp;
  div1_t d1_q;
  div2_t d2_q;
  lin_t  ln_q;
  emit_t em_q;
  logic  d1_adv, d2_adv, ln_adv, em_last, em_free, ln_free, d2_free, accept;
  logic [8:0]  ny, nz;
  logic [31:0] dv1, dv2, dl1, dl2;
  logic [25:0] base_w;
  logic [23:0] vtx [4];
  logic [24:0] vsum;

  logic        rv_q, err_q, last_q;
  logic [2:0]  tn_q;
  logic [23:0] va_q, vb_q, vc_q, vd_q;

  assign cfg_ready_o = 1'b1;
  assign clamp = ({2'b0, cfg_data_i} > 10'(MAX_CUBES_PER_AXIS)) ?
                 8'(MAX_CUBES_PER_AXIS) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= 8'd1;
      cy_q <= 8'd1;
      cz_q <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CUBES_X: cx_q <= clamp;
        REG_CUBES_Y: cy_q <= clamp;
        REG_CUBES_Z: cz_q <= clamp;
        default: ;
      endcase
    end
  end

  assign ny = {1'b0, cy_q} + 9'd1;
  assign nz = {1'b0, cz_q} + 9'd1;

  // stage handoff
  assign em_last = em_q.v & (em_q.err | (em_q.t == 3'(NumTets - 1)));
  assign em_free = !em_q.v | em_last;
  assign ln_adv  = ln_q.v & (ln_q.cnt == 3'd2) & em_free;
  assign ln_free = !ln_q.v | ln_adv;
  assign d2_adv  = d2_q.v & (d2_q.cnt == 3'd6) & ln_free;
  assign d2_free = !d2_q.v | d2_adv;
  assign d1_adv  = d1_q.v & (d1_q.cnt == 3'd6) & d2_free;
  assign busy    = d1_q.v & !d1_adv;
  assign accept  = start & !busy;

  assign dl1 = div4(8'd0, cube_index_i, cz_q);
  assign dv1 = div4(d1_q.rem, d1_q.quo, cz_q);
  assign dl2 = div4(8'd0, d1_q.quo, cy_q);
  assign dv2 = div4(d2_q.rem, d2_q.quo, cy_q);

  // z fastest: first division by cubes_z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
    end else if (accept) begin
      d1_q.v   <= 1'b1;
      d1_q.cnt <= 3'd1;
      d1_q.rem <= dl1[31:24];
      d1_q.quo <= dl1[23:0];
      d1_q.idx <= cube_index_i;
      d1_q.cxy <= {8'd0, cx_q} * {8'd0, cy_q};
      d1_q.err <= 1'b0;
    end else if (d1_q.v) begin
      if (d1_q.cnt != 3'd6) begin
        d1_q.cnt <= d1_q.cnt + 3'd1;
        d1_q.rem <= dv1[31:24];
        d1_q.quo <= dv1[23:0];
      end
      if (d1_q.cnt == 3'd1) d1_q.tot <= {8'd0, d1_q.cxy} * {16'd0, cz_q};
      if (d1_q.cnt == 3'd2) d1_q.err <= d1_q.idx >= d1_q.tot;
      if (d1_adv) d1_q.v <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_q <= '0;
    end else if (d1_adv) begin
      d2_q.v   <= 1'b1;
      d2_q.cnt <= 3'd1;
      d2_q.rem <= dl2[31:24];
      d2_q.quo <= dl2[23:0];
      d2_q.z   <= d1_q.rem;
      d2_q.err <= d1_q.err;
    end else if (d2_q.v) begin
      if (d2_q.cnt != 3'd6) begin
        d2_q.cnt <= d2_q.cnt + 3'd1;
        d2_q.rem <= dv2[31:24];
        d2_q.quo <= dv2[23:0];
      end
      if (d2_adv) d2_q.v <= 1'b0;
    end
  end

  // linearize the cube origin over the point grid
  assign base_w = ({9'd0, ln_q.m + {9'd0, ln_q.y}} * {17'd0, ln_q.nz}) + {18'd0, ln_q.z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_q <= '0;
    end else if (d2_adv) begin
      ln_q.v   <= 1'b1;
      ln_q.cnt <= 3'd1;
      ln_q.y   <= d2_q.rem;
      ln_q.z   <= d2_q.z;
      ln_q.nz  <= nz;
      ln_q.m   <= {9'd0, d2_q.quo[7:0]} * {8'd0, ny};
      ln_q.snz <= {8'd0, ny} * {8'd0, nz};
      ln_q.err <= d2_q.err;
    end else if (ln_q.v) begin
      if (ln_q.cnt == 3'd1) begin
        ln_q.cnt  <= 3'd2;
        ln_q.base <= base_w[23:0];
      end
      if (ln_adv) ln_q.v <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_q <= '0;
    end else if (ln_adv) begin
      em_q.v    <= 1'b1;
      em_q.t    <= 3'd0;
      em_q.nz   <= ln_q.nz;
      em_q.snz  <= ln_q.snz;
      em_q.base <= ln_q.base;
      em_q.err  <= ln_q.err;
    end else if (em_q.v) begin
      if (em_last) em_q.v <= 1'b0;
      else         em_q.t <= em_q.t + 3'd1;
    end
  end

  always_comb begin
    offset_t o;
    for (int k = 0; k < 4; k++) begin
      o      = CORNER_OFS[TET_CORNER[em_q.t][k]];
      vsum   = {1'b0, em_q.base} + (o[2] ? {8'd0, em_q.snz} : 25'd0) +
               (o[1] ? {16'd0, em_q.nz} : 25'd0) + {24'd0, o[0]};
      vtx[k] = em_q.err ? 24'd0 : vsum[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q   <= 1'b0;
      err_q  <= 1'b0;
      last_q <= 1'b0;
      tn_q   <= '0;
      va_q   <= '0;
      vb_q   <= '0;
      vc_q   <= '0;
      vd_q   <= '0;
    end else begin
      rv_q   <= em_q.v;
      err_q  <= em_q.err;
      last_q <= em_last;
      tn_q   <= em_q.err ? 3'd0 : em_q.t;
      va_q   <= vtx[0];
      vb_q   <= vtx[1];
      vc_q   <= vtx[2];
      vd_q   <= vtx[3];
    end
  end

  assign result_valid_o = rv_q;
  assign tet_number_o   = tn_q;
  assign vertex_a_o     = va_q;
  assign vertex_b_o     = vb_q;
  assign vertex_c_o     = vc_q;
  assign vertex_d_o     = vd_q;
  assign index_error_o  = err_q & rv_q;
  assign last_of_cube_o = last_q & rv_q;

endmodule

### rtl/core/ctig_checker.sv
// ----------------------------------------------------------------------------
// ctig_checker
// Port-level checks on the result sequence of the index generator.
// ----------------------------------------------------------------------------
module ctig_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic [2:0] tet_number_o,
  input logic       index_error_o,
  input logic       last_of_cube_o
);

  // a cube's results come back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_cube_o |=> result_valid_o)
    else $error("result burst broken");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_cube_o |=> tet_number_o == $past(tet_number_o) + 3'd1)
    else $error("tetrahedron number out of sequence");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && index_error_o |-> last_of_cube_o && tet_number_o == 3'd0)
    else $error("error result malformed");

  a_last_five: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_cube_o && !index_error_o |-> tet_number_o == 3'd5)
    else $error("last result not the sixth");

endmodule

bind cube_tetrahedra_index_generator ctig_checker u_ctig_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .tet_number_o   (tet_number_o),
  .index_error_o  (index_error_o),
  .last_of_cube_o (last_of_cube_o)
);

### bench/tb_cube_tetrahedra_index_generator.sv
// ----------------------------------------------------------------------------
// tb_cube_tetrahedra_index_generator
// Drives cube index requests under several grid sizes, including the extremes,
// zero counts and unknown register writes, predicts the six tetrahedra of each
// cube (or the single error result) and checks every result in order.
// ----------------------------------------------------------------------------
module tb_cube_tetrahedra_index_generator;
  import ctig_pkg::*;

  localparam int unsigned MaxCount = 255;

  typedef struct {
    logic [2:0]  tet;
    logic [23:0] va;
    logic [23:0] vb;
    logic [23:0] vc;
    logic [23:0] vd;
    logic        err;
    logic        last;
  } tet_result_t;

  class tet_scoreboard;
    tet_result_t pending[$];
    int unsigned cnt_x = 1;
    int unsigned cnt_y = 1;
    int unsigned cnt_z = 1;
    int unsigned fails = 0;
    int unsigned checked = 0;
    int unsigned errs_seen = 0;

    function void set_count(logic [1:0] idx, logic [7:0] val);
      int unsigned v;
      v = (val > MaxCount) ? MaxCount : val;
      if (idx == REG_CUBES_X) cnt_x = v;
      else if (idx == REG_CUBES_Y) cnt_y = v;
      else if (idx == REG_CUBES_Z) cnt_z = v;
    endfunction

    function logic [23:0] point(int unsigned x, int unsigned y, int unsigned z,
                                logic [2:0] corner);
      logic [2:0] o;
      longint unsigned p;
      o = CORNER_OFS[corner];
      p = ((longint'(x + o[2]) * (cnt_y + 1) + (y + o[1])) * (cnt_z + 1)) + (z + o[0]);
      return p[23:0];
    endfunction

    function void note_request(logic [23:0] idx);
      tet_result_t r;
      longint unsigned rest;
      int unsigned x, y, z;
      if (idx >= longint'(cnt_x) * cnt_y * cnt_z) begin
        r = '{3'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1};
        pending.push_back(r);
        return;
      end
      rest = 64'(idx);
      z = 32'(rest % cnt_z);
      rest = rest / cnt_z;
      y = 32'(rest % cnt_y);
      rest = rest / cnt_y;
      x = 32'(rest % cnt_x);
      for (int t = 0; t < NumTets; t++) begin
        r.tet = t[2:0];
        r.va = point(x, y, z, TET_CORNER[t][0]);
        r.vb = point(x, y, z, TET_CORNER[t][1]);
        r.vc = point(x, y, z, TET_CORNER[t][2]);
        r.vd = point(x, y, z, TET_CORNER[t][3]);
        r.err = 1'b0;
        r.last = (t == NumTets - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(tet_result_t got);
      tet_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result tet_number %0d", got.tet);
        fails++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.err) errs_seen++;
      if (got.tet !== e.tet) begin
        $error("tet_number expected %0d actual %0d", e.tet, got.tet); fails++;
      end
      if (got.va !== e.va) begin
        $error("vertex_a expected %0d actual %0d", e.va, got.va); fails++;
      end
      if (got.vb !== e.vb) begin
        $error("vertex_b expected %0d actual %0d", e.vb, got.vb); fails++;
      end
      if (got.vc !== e.vc) begin
        $error("vertex_c expected %0d actual %0d", e.vc, got.vc); fails++;
      end
      if (got.vd !== e.vd) begin
        $error("vertex_d expected %0d actual %0d", e.vd, got.vd); fails++;
      end
      if (got.err !== e.err) begin
        $error("index_error expected %0d actual %0d", e.err, got.err); fails++;
      end
      if (got.last !== e.last) begin
        $error("last_of_cube expected %0d actual %0d", e.last, got.last); fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [23:0] cube_index_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        result_valid_o;
  logic [2:0]  tet_number_o;
  logic [23:0] vertex_a_o;
  logic [23:0] vertex_b_o;
  logic [23:0] vertex_c_o;
  logic [23:0] vertex_d_o;
  logic        index_error_o;
  logic        last_of_cube_o;

  tet_scoreboard sb;
  int unsigned   n_requests;
  bit            quiet;

  cube_tetrahedra_index_generator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cube_index_i   (cube_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .tet_number_o   (tet_number_o),
    .vertex_a_o     (vertex_a_o),
    .vertex_b_o     (vertex_b_o),
    .vertex_c_o     (vertex_c_o),
    .vertex_d_o     (vertex_d_o),
    .index_error_o  (index_error_o),
    .last_of_cube_o (last_of_cube_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{tet_number_o, vertex_a_o, vertex_b_o, vertex_c_o, vertex_d_o,
                        index_error_o, last_of_cube_o});
    end
  end

  // start stays high between back to back requests
  task automatic send_cube(logic [23:0] idx);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cube_index_i <= idx;
    do @(posedge clk_i); while (busy);
    sb.note_request(idx);
    n_requests++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_count(logic [1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(idx, val);
  endtask

  task automatic set_grid(logic [7:0] x, logic [7:0] y, logic [7:0] z);
    wait_drained();
    write_count(REG_CUBES_X, x);
    write_count(REG_CUBES_Y, y);
    write_count(REG_CUBES_Z, z);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    longint unsigned total;
    logic [23:0] idx;
    for (int i = 0; i < n; i++) begin
      total = longint'(sb.cnt_x) * sb.cnt_y * sb.cnt_z;
      case ($urandom_range(0, 9))
        0: idx = 24'($urandom());
        1: idx = (total > 0 && total <= 24'hFFFFFF) ? total[23:0] : 24'hFFFFFF;
        2: idx = (total > 0) ? 24'(total - 1) : 24'd0;
        default: idx = (total > 0) ? 24'($urandom() % total) : 24'($urandom());
      endcase
      send_cube(idx);
    end
  endtask

  initial begin
    sb = new();
    n_requests = 0;
    quiet = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cube_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset counts: single cube
    send_cube(24'd0);
    send_cube(24'd1);
    send_cube(24'hFFFFFF);
    set_grid(8'd255, 8'd255, 8'd255);
    send_cube(24'd0);
    send_cube(24'd16581374);
    send_cube(24'd16581375);
    send_cube(24'hFFFFFF);
    send_cube(24'hAAAAAA);
    send_cube(24'h555555);
    set_grid(8'd3, 8'd0, 8'd4);
    send_cube(24'd0);
    send_cube(24'd5);
    wait_drained();
    write_count(2'd3, 8'd9);
    set_grid(8'd2, 8'd3, 8'd4);
    for (int i = 0; i < 6; i++) send_cube(24'(i * 5));
    send_cube(24'd23);
    send_cube(24'd24);

    set_grid(8'd7, 8'd5, 8'd9);
    random_phase(80);
    set_grid(8'd255, 8'd1, 8'd255);
    random_phase(60);
    wait_drained();
    random_phase(20);
    set_grid(8'd1, 8'd255, 8'd1);
    random_phase(60);
    set_grid(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
             8'($urandom_range(1, 255)));
    random_phase(80);
    set_grid(8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
             8'($urandom_range(1, 16)));
    random_phase(60);
    quiet = 1;
    random_phase(60);
    wait_drained();

    $display("requests: %0d, results checked: %0d, error results: %0d",
             n_requests, sb.checked, sb.errs_seen);
    $display("grid sizes covered 1 to 255 per axis, zero and unknown register writes");
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### cube_tetrahedra_index_generator.f
rtl/core/ctig_pkg.sv
rtl/core/cube_tetrahedra_index_generator.sv
rtl/core/ctig_checker.sv
bench/tb_cube_tetrahedra_index_generator.sv
